@@ rtl/nbg_pkg.sv @@
// Shared types, codes and constants of the gravity derivative unit.
// No dependencies; imported by nbg_term and nbody_gravity_derivative.
package nbg_pkg;

  localparam int IDX_W     = 10;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 11;
  localparam int REG_IDX_W = 2;
  localparam int MAG_W     = 41;
  localparam int NORM_W    = 52;
  localparam int EXP_W     = 6;

  localparam logic [REG_IDX_W-1:0] REG_BODY_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRAV_CONST = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SOFT_RSQ   = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [CNT_W-1:0]  BODY_COUNT_RST = 11'd0;
  localparam logic [DATA_W-1:0] GRAV_CONST_RST = 32'd65536;
  localparam logic [DATA_W-1:0] SOFT_RSQ_RST   = 32'd41;

  localparam logic [MAG_W-1:0] TERM_CAP  = 41'h100_0000_0000;
  localparam logic [63:0]      SEED_BASE = 64'd1275068416;
  localparam logic [63:0]      THREE_Q30 = 64'd3221225472;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDI,
    S_CAPI,
    S_NEXT,
    S_RDJ,
    S_TERM,
    S_DONE
  } top_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_CLAMP,
    ST_NORM,
    ST_SEED,
    ST_Y2,
    ST_Q,
    ST_Y,
    ST_C1,
    ST_C2,
    ST_GM,
    ST_AD,
    ST_MG,
    ST_SHF,
    ST_CAP
  } term_step_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } term_res_t;

  function automatic logic [DATA_W-1:0] sat32(input logic [63:0] v);
    logic [DATA_W-1:0] r;
    if ($signed(v) > 64'sh0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if ($signed(v) < -64'sh0000_0000_8000_0000) r = 32'h8000_0000;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/nbg_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module nbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/nbg_mul.sv @@
// Multi-cycle 64x64 multiplier on one registered 32x32 product, 128-bit result.
// Depends on nothing; used by nbg_term.
module nbg_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] p
);

  logic [63:0]  a_r, b_r;
  logic [1:0]   cnt_r;
  logic         run_r, pp_v_r, last_r, done_r;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic [127:0] acc_r;
  logic [127:0] pp_sh;
  logic [31:0]  a_half, b_half;

  assign a_half = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = cnt_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    case (sh_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      2'd2:    pp_sh = {pp_r, 64'd0};
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pp_v_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      pp_v_r <= run_r;
      if (start) begin
        a_r   <= a;
        b_r   <= b;
        cnt_r <= '0;
        run_r <= 1'b1;
        acc_r <= '0;
      end else begin
        if (run_r) begin
          pp_r   <= a_half * b_half;
          sh_r   <= 2'({1'b0, cnt_r[1]} + {1'b0, cnt_r[0]});
          last_r <= (cnt_r == 2'd3);
          cnt_r  <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            run_r <= 1'b0;
          end
        end
        if (pp_v_r) begin
          acc_r <= acc_r + pp_sh;
          if (last_r) begin
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

@@ rtl/nbg_term.sv @@
// One pairwise interaction: softened distance, Newton inverse cube, scaled terms.
// Depends on nbg_pkg and nbg_mul.
module nbg_term
  import nbg_pkg::*;
#(
  parameter int RSQRT_ITERATIONS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [2:0][DATA_W-1:0] pos_i,
  input  logic [2:0][DATA_W-1:0] pos_j,
  input  logic [DATA_W-1:0]      mass,
  input  logic [DATA_W-1:0]      grav,
  input  logic [DATA_W-1:0]      soft_rsq,
  output logic                   done,
  output term_res_t              res
);

  localparam int KW = $clog2(RSQRT_ITERATIONS + 1);

  term_step_t step_r, step_nxt;

  logic [2:0][DATA_W-1:0] ad_r;
  logic [2:0]             neg_r;
  logic [2:0][MAG_W-1:0]  mag_r;
  logic [DATA_W-1:0]      mass_r;
  logic [NORM_W-1:0]      d_r, m_r, dcl;
  logic signed [EXP_W-1:0] s_r;
  logic [63:0]            y_r, y2_r, t_r, y3_r, gm_r, pr_r, lo, q;
  logic [127:0]           full_r, shf_r;
  logic [1:0]             c_r;
  logic [KW-1:0]          k_r;
  logic                   wait_r, done_r;
  logic                   mul_start, mul_done, is_mul, m_hi, m_lo, k_last;
  logic [63:0]            mul_a, mul_b;
  logic [127:0]           mul_p;
  logic [6:0]             sh7;
  logic [33:0]            m3;
  int                     shi;
  logic signed [32:0]     dx [3];

  nbg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign lo     = mul_p[63:0];
  assign q      = lo >> 30;
  assign m_hi   = |m_r[NORM_W-1:32];
  assign m_lo   = (m_r[31:30] == 2'b00);
  assign k_last = (32'(k_r) + 32'd1 == RSQRT_ITERATIONS);
  assign m3     = {2'b00, m_r[31:0]} + {1'b0, m_r[31:0], 1'b0};

  always_comb begin
    shi = 83 + 3 * int'(s_r);
    sh7 = shi[6:0];
  end

  always_comb begin
    dcl = (d_r < NORM_W'(soft_rsq)) ? NORM_W'(soft_rsq) : d_r;
    if (dcl == '0) begin
      dcl = NORM_W'(1);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dx[c] = $signed({pos_j[c][DATA_W-1], pos_j[c]}) - $signed({pos_i[c][DATA_W-1], pos_i[c]});
    end
  end

  always_comb begin
    is_mul = step_r inside {ST_SQ, ST_Y2, ST_Q, ST_Y, ST_C1, ST_C2, ST_GM, ST_AD, ST_MG};
    mul_start = is_mul && !wait_r;
    case (step_r)
      ST_SQ:        begin mul_a = 64'(ad_r[c_r]); mul_b = 64'(ad_r[c_r]); end
      ST_Y2, ST_C1: begin mul_a = y_r;            mul_b = y_r;            end
      ST_Q:         begin mul_a = 64'(m_r[31:0]); mul_b = y2_r;           end
      ST_Y:         begin mul_a = y_r;            mul_b = t_r;            end
      ST_C2:        begin mul_a = y2_r;           mul_b = y_r;            end
      ST_GM:        begin mul_a = 64'(grav);      mul_b = 64'(mass_r);    end
      ST_AD:        begin mul_a = 64'(ad_r[c_r]); mul_b = y3_r;           end
      ST_MG:        begin mul_a = gm_r;           mul_b = pr_r;           end
      default:      begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    case (step_r)
      ST_IDLE:  if (start) step_nxt = ST_SQ;
      ST_SQ:    if (mul_done && c_r == 2'd2) step_nxt = ST_CLAMP;
      ST_CLAMP: step_nxt = ST_NORM;
      ST_NORM:  if (!m_hi && !m_lo) step_nxt = ST_SEED;
      ST_SEED:  step_nxt = ST_Y2;
      ST_Y2:    if (mul_done) step_nxt = ST_Q;
      ST_Q:     if (mul_done) step_nxt = ST_Y;
      ST_Y:     if (mul_done) step_nxt = k_last ? ST_C1 : ST_Y2;
      ST_C1:    if (mul_done) step_nxt = ST_C2;
      ST_C2:    if (mul_done) step_nxt = ST_GM;
      ST_GM:    if (mul_done) step_nxt = ST_AD;
      ST_AD:    if (mul_done) step_nxt = ST_MG;
      ST_MG:    if (mul_done) step_nxt = ST_SHF;
      ST_SHF:   step_nxt = ST_CAP;
      ST_CAP:   step_nxt = (c_r == 2'd2) ? ST_IDLE : ST_AD;
      default:  step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= 1'b0;
      done_r <= 1'b0;
      c_r    <= '0;
      k_r    <= '0;
    end else begin
      done_r <= (step_r == ST_CAP) && (c_r == 2'd2);
      if (mul_start) begin
        wait_r <= 1'b1;
      end else if (mul_done) begin
        wait_r <= 1'b0;
      end
      case (step_r)
        ST_IDLE: begin
          if (start) begin
            for (int c = 0; c < 3; c++) begin
              neg_r[c] <= dx[c][32];
              ad_r[c]  <= dx[c][32] ? 32'(-dx[c]) : dx[c][31:0];
            end
            mass_r <= mass;
            d_r    <= '0;
            s_r    <= '0;
            c_r    <= '0;
            k_r    <= '0;
          end
        end
        ST_SQ: begin
          if (mul_done) begin
            d_r <= d_r + NORM_W'(lo[63:16]);
            c_r <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
          end
        end
        ST_CLAMP: m_r <= dcl;
        ST_NORM: begin
          if (m_hi) begin
            m_r <= m_r >> 2;
            s_r <= s_r + EXP_W'(1);
          end else if (m_lo) begin
            m_r <= m_r << 2;
            s_r <= s_r - EXP_W'(1);
          end
        end
        ST_SEED: y_r <= SEED_BASE - 64'(m3[33:4]);
        ST_Y2:   if (mul_done) y2_r <= lo >> 30;
        ST_Q:    if (mul_done) t_r <= (q >= THREE_Q30) ? 64'd0 : THREE_Q30 - q;
        ST_Y: begin
          if (mul_done) begin
            y_r <= lo >> 31;
            k_r <= k_r + KW'(1);
          end
        end
        ST_C1:   if (mul_done) y2_r <= lo >> 30;
        ST_C2:   if (mul_done) y3_r <= lo >> 30;
        ST_GM:   if (mul_done) gm_r <= lo;
        ST_AD:   if (mul_done) pr_r <= lo;
        ST_MG:   if (mul_done) full_r <= mul_p;
        ST_SHF:  shf_r <= full_r >> sh7;
        ST_CAP: begin
          mag_r[c_r] <= (shf_r > 128'(TERM_CAP)) ? TERM_CAP : shf_r[MAG_W-1:0];
          c_r        <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign done    = done_r;
  assign res.neg = neg_r;
  assign res.mag = mag_r;

endmodule

@@ rtl/nbody_gravity_derivative.sv @@
// An evaluate runs one interaction for every counted body other than its own index,
// after a set-up that reads its own body; a load writes the body stores directly.
// The shared 32x32 multiplier, four partial products per product, sets the evaluate time.
// One item is worked at a time; a new item is taken while a result waits at the output.
// Synchronous active-low reset clears control and config registers, not data or body stores.
// Depends on nbg_pkg, nbg_ram, nbg_term.
module nbody_gravity_derivative
  import nbg_pkg::*;
#(
  parameter int MAX_BODIES       = 1024,
  parameter int RSQRT_ITERATIONS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [IDX_W-1:0]     in_body_index,
  input  logic [DATA_W-1:0]    in_pos_x,
  input  logic [DATA_W-1:0]    in_pos_y,
  input  logic [DATA_W-1:0]    in_pos_z,
  input  logic [DATA_W-1:0]    in_vel_x,
  input  logic [DATA_W-1:0]    in_vel_y,
  input  logic [DATA_W-1:0]    in_vel_z,
  input  logic [DATA_W-1:0]    in_mass,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_result_index,
  output logic [DATA_W-1:0]    out_dpos_x,
  output logic [DATA_W-1:0]    out_dpos_y,
  output logic [DATA_W-1:0]    out_dpos_z,
  output logic [DATA_W-1:0]    out_acc_x,
  output logic [DATA_W-1:0]    out_acc_y,
  output logic [DATA_W-1:0]    out_acc_z,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  top_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       body_count_r;
  logic [DATA_W-1:0]      grav_r, soft_r;
  logic [IDX_W-1:0]       i_r;
  logic                   i_ok_r;
  logic [CW-1:0]          j_r;
  logic [2:0][DATA_W-1:0] pos_i_r, vel_i_r;
  logic [63:0]            acc_r [3];
  logic                   out_valid_r;
  logic [IDX_W-1:0]       out_idx_r;
  logic [2:0][DATA_W-1:0] out_dpos_r, out_acc_r;

  logic [31:0]            in_idx32, i32, j32, nb32, n32;
  logic                   in_ok, xfer_in, xfer_out, load_we, term_start, term_done, out_load;
  logic [AW-1:0]          raddr;
  logic [3*DATA_W-1:0]    pos_rd, vel_rd;
  logic [DATA_W-1:0]      mass_rd;
  term_res_t              term_res;

  assign in_idx32 = 32'(in_body_index);
  assign in_ok    = in_idx32 < MAX_BODIES;
  assign i32      = 32'(i_r);
  assign j32      = 32'(j_r);
  assign nb32     = 32'(body_count_r);
  assign n32      = (nb32 > MAX_BODIES) ? MAX_BODIES : nb32;
  assign xfer_in  = in_valid && in_ready;
  assign xfer_out = out_valid_r && out_ready;
  assign load_we  = xfer_in && (in_op == OP_LOAD) && in_ok;

  nbg_ram #(.WIDTH(3 * DATA_W), .DEPTH(MAX_BODIES)) u_pos_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_idx32[AW-1:0]),
    .wdata ({in_pos_z, in_pos_y, in_pos_x}),
    .raddr (raddr),
    .rdata (pos_rd)
  );

  nbg_ram #(.WIDTH(3 * DATA_W), .DEPTH(MAX_BODIES)) u_vel_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_idx32[AW-1:0]),
    .wdata ({in_vel_z, in_vel_y, in_vel_x}),
    .raddr (raddr),
    .rdata (vel_rd)
  );

  nbg_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BODIES)) u_mass_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_idx32[AW-1:0]),
    .wdata (in_mass),
    .raddr (raddr),
    .rdata (mass_rd)
  );

  nbg_term #(.RSQRT_ITERATIONS(RSQRT_ITERATIONS)) u_term (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (term_start),
    .pos_i    (pos_i_r),
    .pos_j    (pos_rd),
    .mass     (mass_rd),
    .grav     (grav_r),
    .soft_rsq (soft_r),
    .done     (term_done),
    .res      (term_res)
  );

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    term_start = 1'b0;
    out_load   = 1'b0;
    raddr      = (state_r == S_RDI) ? i32[AW-1:0] : j32[AW-1:0];
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_op == OP_EVAL) state_nxt = S_RDI;
      end
      S_RDI:  state_nxt = S_CAPI;
      S_CAPI: state_nxt = S_NEXT;
      S_NEXT: begin
        if (j32 >= n32) state_nxt = S_DONE;
        else if (j32 != i32) state_nxt = S_RDJ;
      end
      S_RDJ: begin
        term_start = 1'b1;
        state_nxt  = S_TERM;
      end
      S_TERM: if (term_done) state_nxt = S_NEXT;
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_count_r <= BODY_COUNT_RST;
      grav_r       <= GRAV_CONST_RST;
      soft_r       <= SOFT_RSQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BODY_COUNT: body_count_r <= cfg_wdata[CNT_W-1:0];
        REG_GRAV_CONST: grav_r       <= cfg_wdata;
        REG_SOFT_RSQ:   soft_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      j_r         <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (xfer_out) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (xfer_in && in_op == OP_EVAL) begin
            i_r    <= in_body_index;
            i_ok_r <= in_ok;
            j_r    <= '0;
            for (int c = 0; c < 3; c++) acc_r[c] <= '0;
          end
        end
        S_CAPI: begin
          pos_i_r <= i_ok_r ? pos_rd : '0;
          vel_i_r <= i_ok_r ? vel_rd : '0;
        end
        S_NEXT: if (j32 < n32 && j32 == i32) j_r <= j_r + CW'(1);
        S_TERM: begin
          if (term_done) begin
            for (int c = 0; c < 3; c++) begin
              acc_r[c] <= term_res.neg[c] ? acc_r[c] - 64'(term_res.mag[c])
                                          : acc_r[c] + 64'(term_res.mag[c]);
            end
            j_r <= j_r + CW'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_idx_r  <= i_r;
            out_dpos_r <= vel_i_r;
            for (int c = 0; c < 3; c++) out_acc_r[c] <= sat32(acc_r[c]);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_dpos_x       = out_dpos_r[0];
  assign out_dpos_y       = out_dpos_r[1];
  assign out_dpos_z       = out_dpos_r[2];
  assign out_acc_x        = out_acc_r[0];
  assign out_acc_y        = out_acc_r[1];
  assign out_acc_z        = out_acc_r[2];

  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    xfer_in && in_op == OP_EVAL |=> state_r == S_RDI)
    else $error("evaluate transfer did not start a body read");

  a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TERM |-> j32 < n32 && j32 != i32)
    else $error("interaction running on an excluded body");

  a_done_in_term: assert property (@(posedge clk) disable iff (!rst_n)
    term_done |-> state_r == S_TERM)
    else $error("interaction result outside the walk");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && !out_ready |=> state_r == S_DONE)
    else $error("result dropped while output register full");

endmodule
